/* src/dte_pkg.sv */
// ----------------------------------------------------------------------------
// dte_pkg
// shared types and codes of the dominator tree engine
// ----------------------------------------------------------------------------
`default_nettype none
package dte_pkg;
  localparam int NODE_W = 7;
  typedef logic [NODE_W-1:0] node_t;

  localparam logic FUNC_EDGE    = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;

  localparam logic REG_NODE_COUNT  = 1'b0;
  localparam logic REG_SOURCE_NODE = 1'b1;

  typedef enum logic {RET_SEMI, RET_BKT} ret_t;

  typedef enum logic [5:0] {
    S_IDLE, S_CLR, S_INIT,
    S_DRD, S_DUR, S_DSCAN, S_DECHK, S_DVCHK,
    S_SV, S_SW, S_SWR, S_SE, S_SEC, S_SEU,
    S_SBK, S_SSD, S_SSDR, S_SWW, S_BRD, S_BP, S_BLOOP, S_BCRD, S_BCLR, S_BB,
    S_E0, S_E1, S_E2, S_E3, S_U0, S_U1, S_U2, S_U3, S_U4, S_U5, S_ERET, S_ERD,
    S_FV, S_FW, S_FWR, S_FSD, S_FID,
    S_EMIT, S_DONE
  } state_t;
endpackage
`default_nettype wire

/* src/dominator_tree_engine.sv */
// ----------------------------------------------------------------------------
// dominator_tree_engine
// immediate dominators of a loaded graph by the lengauer-tarjan method
// ----------------------------------------------------------------------------
// usage:
//   config: cfg_we with cfg_addr 0 (node_count) or 1 (source_node), only
//   while busy is low
//   items: start with busy low accepts an item; func 0 (busy stays low)
//   stores edge_from -> edge_to if in range and not full, else flags overflow
//   func 1 runs the whole computation: busy rises, a clearing pass over
//   all MAX_NODES+1 entries resets the node table, then a depth-first walk,
//   the semidominator / bucket pass and a fix-up pass run out of the node
//   memory, one read per cycle
//   results: one per node, node 1..n in order, one per cycle, each shown on
//   node / dominator / last / overflow for one cycle with valid high;
//   the receiver cannot stall, nothing waits on it
//   the edge store and the overflow flag are emptied after the last result
//   reset: synchronous rst, config back to node 1 of 1, edge store empty
//   state: one node record memory, a vertex-by-number memory, the edge store
//   and a small compression path memory, all with registered reads
// ----------------------------------------------------------------------------
`default_nettype none
module dominator_tree_engine
  import dte_pkg::*;
#(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [6:0]  cfg_data,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic        func,
  input  wire logic [6:0]  edge_from,
  input  wire logic [6:0]  edge_to,
  output      logic        valid,
  output      logic [6:0]  node,
  output      logic [6:0]  dominator,
  output      logic        last,
  output      logic        overflow
);
  localparam int NAW = $clog2(MAX_NODES + 1);     // node memory address
  localparam int PAW = $clog2(MAX_NODES);         // path memory address
  localparam int LW  = $clog2(MAX_NODES + 1);     // path length
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);     // edge count / cursor

  typedef struct packed {
    node_t pre, par, semi, idom, anc, lab, bh, bn;
    logic [ECW-1:0] cur;
  } nrec_t;

  // memories
  nrec_t nmem [0:MAX_NODES];
  node_t vmem [0:MAX_NODES];
  node_t tmem [0:MAX_EDGES-1];
  node_t hmem [0:MAX_EDGES-1];
  node_t pmem [0:MAX_NODES-1];

  nrec_t nr_q, nr_wdata;
  node_t nr_raddr, nr_waddr;
  logic  nr_we;
  node_t v_q, v_raddr, v_waddr, v_wdata;
  logic  v_we;
  node_t et_q, eh_q;
  logic [ECW-1:0] e_raddr;
  node_t pm_q;
  logic [LW-1:0] pm_raddr, pm_waddr;
  logic  pm_we;
  logic  ed_we;

  // registers
  state_t st, st_next;
  node_t node_count, source_node;
  logic [ECW-1:0] edges_loaded, edges_loaded_next, e, e_next;
  logic  edge_dropped, edge_dropped_next;
  node_t k, k_next, cnt, cnt_next, i, i_next, u, u_next, v, v_next;
  node_t w, w_next, p, p_next, b, b_next, t, t_next, x, x_next;
  node_t lab0, lab0_next, top_anc, top_anc_next, tsemi, tsemi_next;
  logic [LW-1:0] len, len_next;
  nrec_t urec, urec_next, wrec, wrec_next, crec, crec_next, xrec, xrec_next;
  ret_t  ret, ret_next;
  logic  em_pend, em_pend_next, em_last, em_last_next;
  node_t em_k, em_k_next;

  node_t n;
  logic  edge_ok;

  // active node count, saturated to 1..MAX_NODES
  always_comb begin
    if (node_count == '0) begin
      n = node_t'(1);
    end else if (node_count > node_t'(MAX_NODES)) begin
      n = node_t'(MAX_NODES);
    end else begin
      n = node_count;
    end
  end

  assign busy = (st != S_IDLE);
  assign edge_ok = (edge_from != '0) && (edge_from <= n) && (edge_to != '0) &&
                   (edge_to <= n) && (edges_loaded < ECW'(MAX_EDGES));

  always_comb begin
    nrec_t rec;
    st_next = st;
    edges_loaded_next = edges_loaded;
    edge_dropped_next = edge_dropped;
    e_next = e; k_next = k; cnt_next = cnt; i_next = i; u_next = u; v_next = v;
    w_next = w; p_next = p; b_next = b; t_next = t; x_next = x;
    lab0_next = lab0; top_anc_next = top_anc; tsemi_next = tsemi; len_next = len;
    urec_next = urec; wrec_next = wrec; crec_next = crec; xrec_next = xrec;
    ret_next = ret;
    em_pend_next = 1'b0; em_last_next = 1'b0; em_k_next = em_k;
    nr_raddr = '0; nr_we = 1'b0; nr_waddr = '0; nr_wdata = '0;
    v_raddr = '0; v_we = 1'b0; v_waddr = '0; v_wdata = '0;
    e_raddr = '0; ed_we = 1'b0;
    pm_raddr = '0; pm_we = 1'b0; pm_waddr = '0;
    rec = '0;
    unique case (st)
      S_IDLE: begin
        if (start) begin
          if (func == FUNC_EDGE) begin
            if (edge_ok) begin
              ed_we = 1'b1;
              edges_loaded_next = edges_loaded + 1'b1;
            end else begin
              edge_dropped_next = 1'b1;
            end
          end else begin
            k_next = '0;
            st_next = S_CLR;
          end
        end
      end
      // clearing pass over the node table
      S_CLR: begin
        nr_we = 1'b1; nr_waddr = k;
        if (k == node_t'(MAX_NODES)) begin
          st_next = S_INIT;
        end else begin
          k_next = k + 1'b1;
        end
      end
      S_INIT: begin
        if (source_node == '0 || source_node > n) begin
          k_next = node_t'(1);
          st_next = S_EMIT;
        end else begin
          rec.pre = node_t'(1); rec.semi = node_t'(1); rec.lab = source_node;
          nr_we = 1'b1; nr_waddr = source_node; nr_wdata = rec;
          v_we = 1'b1; v_waddr = node_t'(1); v_wdata = source_node;
          cnt_next = node_t'(1);
          u_next = source_node; urec_next = rec; e_next = '0;
          st_next = S_DSCAN;
        end
      end
      // depth-first walk, stack kept as parent links
      S_DRD: begin
        nr_raddr = u; st_next = S_DUR;
      end
      S_DUR: begin
        urec_next = nr_q; e_next = nr_q.cur; st_next = S_DSCAN;
      end
      S_DSCAN: begin
        if (e < edges_loaded) begin
          e_raddr = e; st_next = S_DECHK;
        end else begin
          rec = urec; rec.cur = e;
          nr_we = 1'b1; nr_waddr = u; nr_wdata = rec;
          if (u == source_node) begin
            i_next = cnt;
            if (cnt >= node_t'(2)) begin
              st_next = S_SV;
            end else begin
              k_next = node_t'(1); st_next = S_EMIT;
            end
          end else begin
            u_next = urec.par; st_next = S_DRD;
          end
        end
      end
      S_DECHK: begin
        if (et_q != u || eh_q > n) begin
          e_next = e + 1'b1; st_next = S_DSCAN;
        end else begin
          v_next = eh_q;
          rec = urec; rec.cur = e + 1'b1;
          urec_next = rec;
          nr_we = 1'b1; nr_waddr = u; nr_wdata = rec;
          nr_raddr = eh_q;
          st_next = S_DVCHK;
        end
      end
      S_DVCHK: begin
        if (v != u && nr_q.pre == '0 && cnt < n) begin
          rec = nr_q;
          rec.pre = cnt + 1'b1; rec.semi = cnt + 1'b1; rec.lab = v;
          rec.par = u; rec.cur = '0;
          nr_we = 1'b1; nr_waddr = v; nr_wdata = rec;
          v_we = 1'b1; v_waddr = cnt + 1'b1; v_wdata = v;
          cnt_next = cnt + 1'b1;
          u_next = v; urec_next = rec; e_next = '0;
        end else begin
          e_next = e + 1'b1;
        end
        st_next = S_DSCAN;
      end
      // semidominators in decreasing preorder
      S_SV: begin
        v_raddr = i; st_next = S_SW;
      end
      S_SW: begin
        w_next = v_q; nr_raddr = v_q; st_next = S_SWR;
      end
      S_SWR: begin
        wrec_next = nr_q; e_next = '0; st_next = S_SE;
      end
      S_SE: begin
        if (e < edges_loaded) begin
          e_raddr = e; st_next = S_SEC;
        end else begin
          st_next = S_SBK;
        end
      end
      S_SEC: begin
        if (eh_q != w || et_q > n) begin
          e_next = e + 1'b1; st_next = S_SE;
        end else begin
          u_next = et_q; nr_raddr = et_q; st_next = S_SEU;
        end
      end
      S_SEU: begin
        if (nr_q.pre == '0) begin
          e_next = e + 1'b1; st_next = S_SE;
        end else begin
          v_next = u; ret_next = RET_SEMI; st_next = S_E0;
        end
      end
      // link-eval: find best label of v with path compression
      S_E0: begin
        nr_raddr = v; st_next = S_E1;
      end
      S_E1: begin
        crec_next = nr_q; lab0_next = nr_q.lab;
        if (nr_q.anc == '0) begin
          t_next = nr_q.lab; st_next = S_ERET;
        end else begin
          len_next = '0; st_next = S_E2;
        end
      end
      S_E2: begin
        nr_raddr = crec.anc; st_next = S_E3;
      end
      S_E3: begin
        if (nr_q.anc != '0 && len < LW'(MAX_NODES)) begin
          pm_we = 1'b1; pm_waddr = len;
          len_next = len + 1'b1;
          v_next = crec.anc; crec_next = nr_q;
          st_next = S_E2;
        end else begin
          top_anc_next = crec.anc;
          if (len == '0) begin
            t_next = lab0; st_next = S_ERET;
          end else begin
            st_next = S_U0;
          end
        end
      end
      S_U0: begin
        len_next = len - 1'b1; pm_raddr = len - 1'b1; st_next = S_U1;
      end
      S_U1: begin
        x_next = pm_q; nr_raddr = pm_q; st_next = S_U2;
      end
      S_U2: begin
        xrec_next = nr_q; nr_raddr = nr_q.anc; st_next = S_U3;
      end
      S_U3: begin
        t_next = nr_q.lab; nr_raddr = nr_q.lab; st_next = S_U4;
      end
      S_U4: begin
        tsemi_next = nr_q.semi; nr_raddr = xrec.lab; st_next = S_U5;
      end
      S_U5: begin
        rec = xrec;
        if (tsemi < nr_q.semi) rec.lab = t;
        rec.anc = top_anc;
        nr_we = 1'b1; nr_waddr = x; nr_wdata = rec;
        if (len == '0) begin
          t_next = rec.lab; st_next = S_ERET;
        end else begin
          st_next = S_U0;
        end
      end
      S_ERET: begin
        nr_raddr = t; st_next = S_ERD;
      end
      S_ERD: begin
        tsemi_next = nr_q.semi;
        if (ret == RET_SEMI) begin
          if (nr_q.semi < wrec.semi) wrec_next.semi = nr_q.semi;
          e_next = e + 1'b1; st_next = S_SE;
        end else begin
          nr_raddr = b; st_next = S_BB;
        end
      end
      // bucket insert and link, then the parent's bucket is processed and emptied
      S_SBK: begin
        v_raddr = wrec.semi; st_next = S_SSD;
      end
      S_SSD: begin
        x_next = v_q; nr_raddr = v_q; st_next = S_SSDR;
      end
      S_SSDR: begin
        rec = nr_q; rec.bh = w;
        nr_we = 1'b1; nr_waddr = x; nr_wdata = rec;
        wrec_next.bn = nr_q.bh; wrec_next.anc = wrec.par;
        p_next = wrec.par;
        st_next = S_SWW;
      end
      S_SWW: begin
        nr_we = 1'b1; nr_waddr = w; nr_wdata = wrec; st_next = S_BRD;
      end
      S_BRD: begin
        nr_raddr = p; st_next = S_BP;
      end
      S_BP: begin
        b_next = nr_q.bh; st_next = S_BLOOP;
      end
      S_BLOOP: begin
        if (b == '0) begin
          st_next = S_BCRD;
        end else begin
          v_next = b; ret_next = RET_BKT; st_next = S_E0;
        end
      end
      S_BB: begin
        rec = nr_q;
        rec.idom = (tsemi < nr_q.semi) ? t : p;
        nr_we = 1'b1; nr_waddr = b; nr_wdata = rec;
        b_next = nr_q.bn; st_next = S_BLOOP;
      end
      S_BCRD: begin
        nr_raddr = p; st_next = S_BCLR;
      end
      S_BCLR: begin
        rec = nr_q; rec.bh = '0;
        nr_we = 1'b1; nr_waddr = p; nr_wdata = rec;
        if (i == node_t'(2)) begin
          st_next = S_FV;
        end else begin
          i_next = i - 1'b1; st_next = S_SV;
        end
      end
      // fix-up in increasing preorder
      S_FV: begin
        v_raddr = i; st_next = S_FW;
      end
      S_FW: begin
        w_next = v_q; nr_raddr = v_q; st_next = S_FWR;
      end
      S_FWR: begin
        wrec_next = nr_q; v_raddr = nr_q.semi; st_next = S_FSD;
      end
      S_FSD: begin
        if (wrec.idom != v_q) begin
          nr_raddr = wrec.idom; st_next = S_FID;
        end else if (i == cnt) begin
          k_next = node_t'(1); st_next = S_EMIT;
        end else begin
          i_next = i + 1'b1; st_next = S_FV;
        end
      end
      S_FID: begin
        rec = wrec; rec.idom = nr_q.idom;
        nr_we = 1'b1; nr_waddr = w; nr_wdata = rec;
        if (i == cnt) begin
          k_next = node_t'(1); st_next = S_EMIT;
        end else begin
          i_next = i + 1'b1; st_next = S_FV;
        end
      end
      // one result per cycle
      S_EMIT: begin
        nr_raddr = k;
        em_pend_next = 1'b1; em_k_next = k; em_last_next = (k == n);
        if (k == n) begin
          st_next = S_DONE;
        end else begin
          k_next = k + 1'b1;
        end
      end
      S_DONE: begin
        edges_loaded_next = '0; edge_dropped_next = 1'b0; st_next = S_IDLE;
      end
      default: st_next = S_IDLE;
    endcase
  end

  // memories with registered reads
  always_ff @(posedge clk) begin
    if (nr_we) nmem[nr_waddr[NAW-1:0]] <= nr_wdata;
    nr_q <= nmem[nr_raddr[NAW-1:0]];
    if (v_we) vmem[v_waddr[NAW-1:0]] <= v_wdata;
    v_q <= vmem[v_raddr[NAW-1:0]];
    if (ed_we) begin
      tmem[edges_loaded[EAW-1:0]] <= edge_from;
      hmem[edges_loaded[EAW-1:0]] <= edge_to;
    end
    et_q <= tmem[e_raddr[EAW-1:0]];
    eh_q <= hmem[e_raddr[EAW-1:0]];
    if (pm_we) pmem[pm_waddr[PAW-1:0]] <= v;
    pm_q <= pmem[pm_raddr[PAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      node_count <= node_t'(1);
      source_node <= node_t'(1);
      edges_loaded <= '0;
      edge_dropped <= 1'b0;
      em_pend <= 1'b0;
      valid <= 1'b0;
    end else begin
      st <= st_next;
      edges_loaded <= edges_loaded_next;
      edge_dropped <= edge_dropped_next;
      em_pend <= em_pend_next;
      valid <= em_pend;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_NODE_COUNT:  node_count <= cfg_data;
          REG_SOURCE_NODE: source_node <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    e <= e_next; k <= k_next; cnt <= cnt_next; i <= i_next; u <= u_next;
    v <= v_next; w <= w_next; p <= p_next; b <= b_next; t <= t_next;
    x <= x_next; lab0 <= lab0_next; top_anc <= top_anc_next;
    tsemi <= tsemi_next; len <= len_next;
    urec <= urec_next; wrec <= wrec_next; crec <= crec_next; xrec <= xrec_next;
    ret <= ret_next; em_k <= em_k_next; em_last <= em_last_next;
    // result register, read data arrives the cycle after the emit read
    node <= em_k;
    dominator <= nr_q.idom;
    last <= em_last;
    overflow <= edge_dropped;
  end
endmodule
`default_nettype wire
